[rtl/qwfc_pkg.sv]
`timescale 1ns / 1ps

package qwfc_pkg;

    // field widths
    localparam int POS_W      = 32;
    localparam int CNT_W      = 32;
    localparam int MSG_SIZE_W = 32;
    localparam int TOTAL_W    = 64;
    localparam int ERR_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // input operations
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE       = 2'd0;
    localparam logic [ERR_W-1:0] ERR_COUNT_UF   = 2'd1;
    localparam logic [ERR_W-1:0] ERR_SIZE_UF    = 2'd2;
    localparam logic [ERR_W-1:0] ERR_TABLE_FULL = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESUME_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_SIZE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RESUME_SIZE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_MODE = 3'd4;

    // operation applied to every cell of the held chain
    typedef enum logic [2:0] {
        CMD_IDLE   = 3'd0,
        CMD_CMP    = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_REMOVE = 3'd3,
        CMD_SHIFT  = 3'd4
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd         cmd;
        logic [POS_W-1:0]  key;
    } t_chain_ctl;

    typedef struct packed {
        logic              hit;
        logic              empty;
        logic              full;
        logic              head_last;
        logic [POS_W-1:0]  head_pos;
    } t_chain_stat;

endpackage

[rtl/qwfc_cell.sv]
`timescale 1ns / 1ps

module qwfc_cell
    import qwfc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_chain_ctl       i_ctl,
    input  logic             i_prev_valid,
    input  logic             i_next_valid,
    input  logic [POS_W-1:0] i_next_pos,
    input  logic             i_pref,
    output logic             o_valid,
    output logic             o_match,
    output logic             o_pref,
    output logic [POS_W-1:0] o_pos
);

    logic             r_valid, n_valid;
    logic             r_match, n_match;
    logic [POS_W-1:0] r_pos, n_pos;

    // next state of this slot
    always_comb begin
        n_valid = r_valid;
        n_match = r_match;
        n_pos   = r_pos;
        case (i_ctl.cmd)
            CMD_CMP: begin
                n_match = r_valid && (r_pos == i_ctl.key);
            end
            CMD_INSERT: begin
                // first free slot of the packed row takes the new word
                if (!r_valid && i_prev_valid) begin
                    n_valid = 1'b1;
                    n_pos   = i_ctl.key;
                end
            end
            CMD_REMOVE: begin
                // matched slot and everything behind it move up one place
                if (i_pref || r_match) begin
                    n_valid = i_next_valid;
                    n_pos   = i_next_pos;
                end
            end
            CMD_SHIFT: begin
                n_valid = i_next_valid;
                n_pos   = i_next_pos;
            end
            default: begin
                n_valid = r_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_match <= n_match;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
    end

    assign o_valid = r_valid;
    assign o_match = r_match;
    assign o_pref  = i_pref | r_match;
    assign o_pos   = r_pos;

endmodule

[rtl/qwfc_chain.sv]
`timescale 1ns / 1ps

module qwfc_chain
    import qwfc_pkg::*;
#(
    parameter int HELD_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_chain_ctl  i_ctl,
    output t_chain_stat o_stat
);

    logic [HELD_DEPTH-1:0] w_valid;
    logic [HELD_DEPTH-1:0] w_match;
    logic [HELD_DEPTH-1:0] w_pref_out;
    logic [HELD_DEPTH-1:0] w_pref_in;
    logic [HELD_DEPTH-1:0] w_prev_valid;
    logic [HELD_DEPTH-1:0] w_next_valid;
    logic [POS_W-1:0]      w_pos      [0:HELD_DEPTH-1];
    logic [POS_W-1:0]      w_next_pos [0:HELD_DEPTH-1];

    // neighbor wiring: slot 0 is the oldest held word
    assign w_prev_valid = {w_valid[HELD_DEPTH-2:0], 1'b1};
    assign w_next_valid = {1'b0, w_valid[HELD_DEPTH-1:1]};
    assign w_pref_in    = {w_pref_out[HELD_DEPTH-2:0], 1'b0};

    for (genvar g = 0; g < HELD_DEPTH; g++) begin : g_cell
        if (g == HELD_DEPTH - 1) begin : g_tail
            assign w_next_pos[g] = '0;
        end else begin : g_body
            assign w_next_pos[g] = w_pos[g+1];
        end

        qwfc_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (i_ctl),
            .i_prev_valid (w_prev_valid[g]),
            .i_next_valid (w_next_valid[g]),
            .i_next_pos   (w_next_pos[g]),
            .i_pref       (w_pref_in[g]),
            .o_valid      (w_valid[g]),
            .o_match      (w_match[g]),
            .o_pref       (w_pref_out[g]),
            .o_pos        (w_pos[g])
        );
    end

    // status back to the controller
    assign o_stat.hit       = |w_match;
    assign o_stat.empty     = !w_valid[0];
    assign o_stat.full      = w_valid[HELD_DEPTH-1];
    assign o_stat.head_last = !w_valid[1];
    assign o_stat.head_pos  = w_pos[0];

endmodule

[rtl/queue_watermark_flow_control.sv]
`timescale 1ns / 1ps
// A result word is loaded into the output register in the held-table state,
// which follows the counter update state; a busy output register holds it there.
// No new input word is taken until the last one's result words are loaded; a resume
// that drains the held table releases its positions one by one via the shift chain.
// Reset (synchronous, active low) clears counters, stopped flag and held table.
module queue_watermark_flow_control
    import qwfc_pkg::*;
#(
    parameter int HELD_DEPTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_op,
    input  logic [POS_W-1:0]      i_position,
    input  logic [MSG_SIZE_W-1:0] i_message_size,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_held,
    output logic                  o_release_valid,
    output logic [POS_W-1:0]      o_released_position,
    output logic                  o_flow_stopped,
    output logic                  o_stop_event,
    output logic [ERR_W-1:0]      o_error_code,
    output logic                  o_last
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CALC  = 4'b0010,
        S_TABLE = 4'b0100,
        S_DRAIN = 4'b1000
    } t_state;

    // configuration
    logic [CNT_W-1:0]   r_stop_cnt, r_resume_cnt;
    logic [TOTAL_W-1:0] r_stop_size, r_resume_size;
    logic               r_cluster;

    // queue state
    logic [CNT_W-1:0]   r_msg_cnt, n_msg_cnt;
    logic [TOTAL_W-1:0] r_byte_total, n_byte_total;
    logic               r_stopped, n_stopped;

    // current word
    t_state                r_state, n_state;
    logic                  r_op;
    logic [POS_W-1:0]      r_pos;
    logic [MSG_SIZE_W-1:0] r_size;
    logic [ERR_W-1:0]      r_err, n_err;
    logic                  r_stop_ev, n_stop_ev;

    // output register
    logic                  r_out_valid, n_out_valid;
    logic                  r_held, n_held;
    logic                  r_rel_valid, n_rel_valid;
    logic [POS_W-1:0]      r_rel_pos, n_rel_pos;
    logic                  r_flow_stopped, n_flow_stopped;
    logic                  r_out_stop_ev, n_out_stop_ev;
    logic [ERR_W-1:0]      r_out_err, n_out_err;
    logic                  r_last, n_last;

    t_chain_ctl  w_ctl;
    t_chain_stat w_stat;

    logic               w_out_free;
    logic               w_in_take;
    logic               w_hold_req;
    logic [CNT_W-1:0]   w_cnt_inc, w_cnt_dec, w_rc;
    logic [TOTAL_W-1:0] w_tot_inc, w_tot_dec, w_size_ext, w_rs;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_take  = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_cnt    <= '0;
            r_resume_cnt  <= '0;
            r_stop_size   <= '0;
            r_resume_size <= '0;
            r_cluster     <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_STOP_COUNT:   r_stop_cnt    <= i_cfg_data[CNT_W-1:0];
                CFG_RESUME_COUNT: r_resume_cnt  <= i_cfg_data[CNT_W-1:0];
                CFG_STOP_SIZE:    r_stop_size   <= i_cfg_data[TOTAL_W-1:0];
                CFG_RESUME_SIZE:  r_resume_size <= i_cfg_data[TOTAL_W-1:0];
                CFG_CLUSTER_MODE: r_cluster     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // capture the accepted word
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_op   <= i_op;
            r_pos  <= i_position;
            r_size <= i_message_size;
        end
    end

    // counter arithmetic
    assign w_size_ext = {{(TOTAL_W-MSG_SIZE_W){1'b0}}, r_size};
    assign w_cnt_inc  = r_msg_cnt + CNT_W'(1);
    assign w_cnt_dec  = r_msg_cnt - CNT_W'(1);
    assign w_tot_inc  = r_byte_total + w_size_ext;
    assign w_tot_dec  = r_byte_total - w_size_ext;
    // zero resume level falls back to the stop level
    assign w_rc = (r_resume_cnt != '0) ? r_resume_cnt : r_stop_cnt;
    assign w_rs = (r_resume_size != '0) ? r_resume_size : r_stop_size;

    assign w_hold_req = (r_stopped || !w_stat.empty) && !r_cluster;

    // control
    always_comb begin
        n_state        = r_state;
        n_msg_cnt      = r_msg_cnt;
        n_byte_total   = r_byte_total;
        n_stopped      = r_stopped;
        n_err          = r_err;
        n_stop_ev      = r_stop_ev;
        n_out_valid    = r_out_valid && !i_out_ready;
        n_held         = r_held;
        n_rel_valid    = r_rel_valid;
        n_rel_pos      = r_rel_pos;
        n_flow_stopped = r_flow_stopped;
        n_out_stop_ev  = r_out_stop_ev;
        n_out_err      = r_out_err;
        n_last         = r_last;
        w_ctl.cmd      = CMD_IDLE;
        w_ctl.key      = r_pos;

        case (r_state)
            S_IDLE: begin
                if (w_in_take) begin
                    n_state = S_CALC;
                end
            end

            // counters, stop and resume decisions; cells compare their slot
            S_CALC: begin
                w_ctl.cmd = CMD_CMP;
                n_err     = ERR_NONE;
                n_stop_ev = 1'b0;
                n_state   = S_TABLE;
                if (r_op == OP_ENQUEUE) begin
                    n_msg_cnt    = w_cnt_inc;
                    n_byte_total = w_tot_inc;
                    if (!r_stopped &&
                        ((r_stop_cnt != '0 && w_cnt_inc > r_stop_cnt) ||
                         (r_stop_size != '0 && w_tot_inc > r_stop_size))) begin
                        n_stopped = 1'b1;
                        n_stop_ev = 1'b1;
                    end
                end else if (r_msg_cnt == '0) begin
                    n_err = ERR_COUNT_UF;
                end else begin
                    n_msg_cnt = w_cnt_dec;
                    if (w_size_ext > r_byte_total) begin
                        n_err = ERR_SIZE_UF;
                    end else begin
                        n_byte_total = w_tot_dec;
                        if (r_stopped &&
                            (w_rs == '0 || w_tot_dec < w_rs) &&
                            (w_rc == '0 || w_cnt_dec < w_rc)) begin
                            n_stopped = 1'b0;
                        end
                    end
                end
            end

            // held-table action and the result word
            S_TABLE: begin
                if (w_out_free) begin
                    n_out_valid    = 1'b1;
                    n_held         = 1'b0;
                    n_rel_valid    = 1'b0;
                    n_rel_pos      = '0;
                    n_flow_stopped = r_stopped;
                    n_out_stop_ev  = 1'b0;
                    n_out_err      = r_err;
                    n_last         = 1'b1;
                    n_state        = S_IDLE;
                    if (r_op == OP_ENQUEUE) begin
                        n_out_stop_ev = r_stop_ev;
                        if (w_hold_req) begin
                            if (w_stat.hit) begin
                                n_held = 1'b1;
                            end else if (!w_stat.full) begin
                                w_ctl.cmd = CMD_INSERT;
                                n_held    = 1'b1;
                            end else begin
                                n_out_err = ERR_TABLE_FULL;
                            end
                        end
                    end else if (r_err == ERR_NONE && !w_stat.empty) begin
                        if (!r_stopped) begin
                            // resume: drain the whole table, no word yet
                            n_out_valid = r_out_valid && !i_out_ready;
                            n_state     = S_DRAIN;
                        end else if (w_stat.hit) begin
                            w_ctl.cmd   = CMD_REMOVE;
                            n_rel_valid = 1'b1;
                            n_rel_pos   = r_pos;
                        end
                    end
                end
            end

            // release held positions in insertion order, one per cycle while the output register is free
            S_DRAIN: begin
                if (w_out_free) begin
                    w_ctl.cmd      = CMD_SHIFT;
                    n_out_valid    = 1'b1;
                    n_held         = 1'b0;
                    n_rel_valid    = 1'b1;
                    n_rel_pos      = w_stat.head_pos;
                    n_flow_stopped = r_stopped;
                    n_out_stop_ev  = 1'b0;
                    n_out_err      = ERR_NONE;
                    n_last         = w_stat.head_last;
                    if (w_stat.head_last) begin
                        n_state = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_msg_cnt    <= '0;
            r_byte_total <= '0;
            r_stopped    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_msg_cnt    <= n_msg_cnt;
            r_byte_total <= n_byte_total;
            r_stopped    <= n_stopped;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_err          <= n_err;
        r_stop_ev      <= n_stop_ev;
        r_held         <= n_held;
        r_rel_valid    <= n_rel_valid;
        r_rel_pos      <= n_rel_pos;
        r_flow_stopped <= n_flow_stopped;
        r_out_stop_ev  <= n_out_stop_ev;
        r_out_err      <= n_out_err;
        r_last         <= n_last;
    end

    qwfc_chain #(
        .HELD_DEPTH (HELD_DEPTH)
    ) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_stat  (w_stat)
    );

    assign o_out_valid         = r_out_valid;
    assign o_held              = r_held;
    assign o_release_valid     = r_rel_valid;
    assign o_released_position = r_rel_pos;
    assign o_flow_stopped      = r_flow_stopped;
    assign o_stop_event        = r_out_stop_ev;
    assign o_error_code        = r_out_err;
    assign o_last              = r_last;

    // draining only happens after a resume, over a non-empty table
    a_drain_resumed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> (!r_stopped && !w_stat.empty))
        else $error("drain while stopped or with empty table");

    // an accepted word always starts the counter update
    a_accept_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_take |=> (r_state == S_CALC))
        else $error("accepted word did not reach counter update");

    // a release word never also reports a hold
    a_release_not_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_rel_valid) |-> !r_held)
        else $error("release word marked as held");

    // the table cannot be full and empty at once
    a_table_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_stat.full && w_stat.empty))
        else $error("held table both full and empty");

endmodule

[sim/queue_watermark_flow_control_tb.sv]
`timescale 1ns / 1ps

module queue_watermark_flow_control_tb;
    import qwfc_pkg::*;

    localparam int HELD_DEPTH    = 64;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 4000;
    localparam int REPORT_MAX    = 10;

    // one result word as the block presents it
    typedef struct packed {
        logic             held;
        logic             rel_valid;
        logic [POS_W-1:0] rel_pos;
        logic             stopped;
        logic             stop_ev;
        logic [ERR_W-1:0] err;
        logic             last;
    } flow_result_t;

    // a message believed to sit in the queue, used to shape dequeues
    typedef struct {
        logic [POS_W-1:0]      pos;
        logic [MSG_SIZE_W-1:0] size;
    } queued_msg_t;

    // predictor of the watermark logic plus the list of result words still owed
    class flow_scoreboard;
        logic [CNT_W-1:0]   stop_cnt;
        logic [CNT_W-1:0]   resume_cnt;
        logic [TOTAL_W-1:0] stop_sz;
        logic [TOTAL_W-1:0] resume_sz;
        logic               cluster;

        logic [CNT_W-1:0]   msg_count;
        logic [TOTAL_W-1:0] byte_total;
        logic               stopped;
        logic [POS_W-1:0]   held_q[$];

        flow_result_t       owed_q[$];

        int mismatches;
        int n_words;
        int n_results;
        int n_releases;
        int n_stop_events;
        int n_underflows;
        int n_full;

        function new();
            stop_cnt      = '0;
            resume_cnt    = '0;
            stop_sz       = '0;
            resume_sz     = '0;
            cluster       = 1'b0;
            msg_count     = '0;
            byte_total    = '0;
            stopped       = 1'b0;
            mismatches    = 0;
            n_words       = 0;
            n_results     = 0;
            n_releases    = 0;
            n_stop_events = 0;
            n_underflows  = 0;
            n_full        = 0;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_STOP_COUNT:   stop_cnt   = val[CNT_W-1:0];
                CFG_RESUME_COUNT: resume_cnt = val[CNT_W-1:0];
                CFG_STOP_SIZE:    stop_sz    = val;
                CFG_RESUME_SIZE:  resume_sz  = val;
                CFG_CLUSTER_MODE: cluster    = val[0];
                default: ;
            endcase
        endfunction

        function int find_held(logic [POS_W-1:0] pos);
            foreach (held_q[i])
                if (held_q[i] == pos) return i;
            return -1;
        endfunction

        // work out the result words caused by one accepted input word
        function void note_word(logic op, logic [POS_W-1:0] pos, logic [MSG_SIZE_W-1:0] size);
            flow_result_t       r;
            logic [TOTAL_W-1:0] rsz;
            logic [CNT_W-1:0]   rcnt;
            int                 slot;
            int                 n;
            r      = '0;
            r.last = 1'b1;
            n_words++;
            if (op == OP_ENQUEUE) begin
                msg_count  = msg_count + 1'b1;
                byte_total = byte_total + {32'b0, size};
                if (!stopped && ((stop_cnt != 0 && msg_count > stop_cnt) ||
                                 (stop_sz != 0 && byte_total > stop_sz))) begin
                    stopped   = 1'b1;
                    r.stop_ev = 1'b1;
                end
                if ((stopped || held_q.size() != 0) && !cluster) begin
                    if (find_held(pos) >= 0) begin
                        r.held = 1'b1;
                    end else if (held_q.size() < HELD_DEPTH) begin
                        held_q.insert(held_q.size(), pos);
                        r.held = 1'b1;
                    end else begin
                        r.err = ERR_TABLE_FULL;
                    end
                end
                r.stopped = stopped;
                owed_q.insert(owed_q.size(), r);
                return;
            end
            // dequeue: count underflow leaves everything alone
            if (msg_count == 0) begin
                r.err     = ERR_COUNT_UF;
                r.stopped = stopped;
                owed_q.insert(owed_q.size(), r);
                return;
            end
            msg_count = msg_count - 1'b1;
            // size underflow keeps the count already lowered
            if ({32'b0, size} > byte_total) begin
                r.err     = ERR_SIZE_UF;
                r.stopped = stopped;
                owed_q.insert(owed_q.size(), r);
                return;
            end
            byte_total = byte_total - {32'b0, size};
            if (stopped) begin
                rsz  = (resume_sz != 0) ? resume_sz : stop_sz;
                rcnt = (resume_cnt != 0) ? resume_cnt : stop_cnt;
                if ((rsz == 0 || byte_total < rsz) && (rcnt == 0 || msg_count < rcnt))
                    stopped = 1'b0;
            end
            r.stopped = stopped;
            if (held_q.size() != 0) begin
                if (!stopped) begin
                    // resume: every held position goes out, oldest first
                    n = held_q.size();
                    foreach (held_q[i]) begin
                        r.rel_valid = 1'b1;
                        r.rel_pos   = held_q[i];
                        r.last      = (i == n - 1);
                        owed_q.insert(owed_q.size(), r);
                    end
                    held_q.delete();
                    return;
                end
                slot = find_held(pos);
                if (slot >= 0) begin
                    held_q.delete(slot);
                    r.rel_valid = 1'b1;
                    r.rel_pos   = pos;
                end
            end
            owed_q.insert(owed_q.size(), r);
        endfunction

        // compare one result word against the oldest one owed
        function void check_word(flow_result_t got);
            flow_result_t want;
            if (owed_q.size() == 0) begin
                if (mismatches < REPORT_MAX)
                    $display("%0t: result word with nothing owed: held=%0b rel=%0b pos=%h",
                             $time, got.held, got.rel_valid, got.rel_pos);
                mismatches++;
                return;
            end
            want = owed_q.pop_front();
            n_results++;
            if (got.held !== want.held || got.rel_valid !== want.rel_valid ||
                got.rel_pos !== want.rel_pos || got.stopped !== want.stopped ||
                got.stop_ev !== want.stop_ev || got.err !== want.err ||
                got.last !== want.last) begin
                if (mismatches < REPORT_MAX) begin
                    $display("%0t: mismatch on result word %0d", $time, n_results);
                    $display("  want held=%0b rel=%0b pos=%h stp=%0b sev=%0b err=%0d last=%0b",
                             want.held, want.rel_valid, want.rel_pos, want.stopped,
                             want.stop_ev, want.err, want.last);
                    $display("  got  held=%0b rel=%0b pos=%h stp=%0b sev=%0b err=%0d last=%0b",
                             got.held, got.rel_valid, got.rel_pos, got.stopped,
                             got.stop_ev, got.err, got.last);
                end
                mismatches++;
            end
            // coverage tallies for the closing summary
            if (want.rel_valid) n_releases++;
            if (want.stop_ev) n_stop_events++;
            if (want.err == ERR_COUNT_UF || want.err == ERR_SIZE_UF) n_underflows++;
            if (want.err == ERR_TABLE_FULL) n_full++;
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n        = 1'b0;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_ready;
    logic                  i_op           = 1'b0;
    logic [POS_W-1:0]      i_position     = '0;
    logic [MSG_SIZE_W-1:0] i_message_size = '0;
    logic                  o_out_valid;
    logic                  i_out_ready    = 1'b0;
    logic                  o_held;
    logic                  o_release_valid;
    logic [POS_W-1:0]      o_released_position;
    logic                  o_flow_stopped;
    logic                  o_stop_event;
    logic [ERR_W-1:0]      o_error_code;
    logic                  o_last;

    flow_scoreboard sb;
    queued_msg_t    live_q[$];
    int             send_idle = 0;
    int             recv_idle = 0;
    int             run_len   = 0;
    int             longest_drain = 0;

    queue_watermark_flow_control #(
        .HELD_DEPTH(HELD_DEPTH)
    ) uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_op               (i_op),
        .i_position         (i_position),
        .i_message_size     (i_message_size),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_held             (o_held),
        .o_release_valid    (o_release_valid),
        .o_released_position(o_released_position),
        .o_flow_stopped     (o_flow_stopped),
        .o_stop_event       (o_stop_event),
        .o_error_code       (o_error_code),
        .o_last             (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // receiver: random stalls on the result side
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // result checking, sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_word({o_held, o_release_valid, o_released_position, o_flow_stopped,
                           o_stop_event, o_error_code, o_last});
            // track the longest run of releases that ends a resume
            if (o_release_valid) run_len++;
            else run_len = 0;
            if (o_last) begin
                if (o_release_valid && !o_flow_stopped && run_len > longest_drain)
                    longest_drain = run_len;
                run_len = 0;
            end
        end
    end

    // watchdog: ends the run when nothing moves for too long
    initial begin
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) stall = 0;
            else stall++;
        end
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("[queue_watermark_flow_control] ERROR");
        $finish;
    end

    // write all five registers; block must be idle
    task automatic load_levels(input logic [CNT_W-1:0] sc, input logic [CNT_W-1:0] rc,
                               input logic [TOTAL_W-1:0] ss, input logic [TOTAL_W-1:0] rs,
                               input logic cm);
        logic [CFG_DATA_W-1:0] vals[5];
        logic [CFG_IDX_W-1:0]  idx[5];
        idx[0]  = CFG_STOP_COUNT;   vals[0] = {32'b0, sc};
        idx[1]  = CFG_RESUME_COUNT; vals[1] = {32'b0, rc};
        idx[2]  = CFG_STOP_SIZE;    vals[2] = ss;
        idx[3]  = CFG_RESUME_SIZE;  vals[3] = rs;
        idx[4]  = CFG_CLUSTER_MODE; vals[4] = {63'b0, cm};
        for (int k = 0; k < 5; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= vals[k];
            sb.write_reg(idx[k], vals[k]);
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // offer one input word and hold it until accepted; returns at a falling edge
    task automatic send_word(input logic op, input logic [POS_W-1:0] pos,
                             input logic [MSG_SIZE_W-1:0] size);
        queued_msg_t m;
        while ($urandom_range(0, 99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_op           <= op;
        i_position     <= pos;
        i_message_size <= size;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_word(op, pos, size);
        // keep the shadow queue in step so later dequeues match real messages
        if (op == OP_ENQUEUE) begin
            m.pos  = pos;
            m.size = size;
            live_q.insert(live_q.size(), m);
        end else begin
            foreach (live_q[i]) begin
                if (live_q[i].pos == pos && live_q[i].size == size) begin
                    live_q.delete(i);
                    break;
                end
            end
        end
        @(negedge i_clk);
    endtask

    // stop offering words until every owed result word is back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [MSG_SIZE_W-1:0] pick_size(input logic [MSG_SIZE_W-1:0] cap);
        if ($urandom_range(0, 9) == 0) return $urandom;
        return $urandom_range(0, cap);
    endfunction

    // fill past the stop level, drain below resume, with some noise mixed in
    task automatic run_traffic(input int n_words, input int hi, input int lo,
                               input logic [MSG_SIZE_W-1:0] cap);
        logic             filling;
        logic             enq;
        int               roll;
        int               k;
        logic [POS_W-1:0] pos;
        filling = 1'b1;
        for (int w = 0; w < n_words; w++) begin
            if (w == n_words / 2) drain_results();
            if (live_q.size() >= hi) filling = 1'b0;
            else if (live_q.size() <= lo) filling = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                // noise: arbitrary op and fields
                send_word(1'($urandom_range(0, 1)), $urandom, $urandom);
            end else if (roll < 11 && live_q.size() != 0) begin
                // re-enqueue a position already in the queue
                k = $urandom_range(0, live_q.size() - 1);
                pos = live_q[k].pos;
                send_word(OP_ENQUEUE, pos, pick_size(cap));
            end else begin
                enq = filling ? ($urandom_range(0, 99) < 85) : ($urandom_range(0, 99) < 15);
                if (live_q.size() == 0) enq = 1'b1;
                if (enq) begin
                    send_word(OP_ENQUEUE, $urandom, pick_size(cap));
                end else begin
                    k = ($urandom_range(0, 99) < 60) ? $urandom_range(0, live_q.size() - 1) : 0;
                    send_word(OP_DEQUEUE, live_q[k].pos, live_q[k].size);
                end
            end
        end
    endtask

    initial begin
        logic [CNT_W-1:0]   sc;
        logic [CNT_W-1:0]   rc;
        logic [TOTAL_W-1:0] ss;
        int                 lo;
        sb = new();
        send_idle = 26;
        recv_idle = 77;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: underflows, extremes, stop, duplicate, single release, resume
        load_levels(32'd4, 32'd2, 64'd0, 64'd0, 1'b0);
        send_word(OP_DEQUEUE, 32'd0, 32'd0);
        send_word(OP_ENQUEUE, 32'd0, 32'd0);
        send_word(OP_DEQUEUE, 32'd0, 32'd1);
        send_word(OP_ENQUEUE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(OP_DEQUEUE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (int p = 10; p < 16; p++) send_word(OP_ENQUEUE, p, 32'd100);
        send_word(OP_ENQUEUE, 32'd14, 32'd100);
        send_word(OP_DEQUEUE, 32'd14, 32'd100);
        for (int p = 10; p < 14; p++) send_word(OP_DEQUEUE, p, 32'd100);
        send_word(OP_DEQUEUE, 32'd20, 32'd100);
        send_word(OP_DEQUEUE, 32'd15, 32'd100);
        send_word(OP_DEQUEUE, 32'd1, 32'd0);
        drain_results();

        // fill the held table past its depth, then resume with a full drain
        load_levels(32'd1, 32'd0, 64'd0, 64'd0, 1'b0);
        for (int p = 0; p < HELD_DEPTH + 2; p++) send_word(OP_ENQUEUE, 32'h8000_0000 + p, p);
        send_word(OP_ENQUEUE, 32'h8000_0001, 32'd0);
        drain_results();
        load_levels(32'd1, 32'hFFFF_FFFF, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_word(OP_DEQUEUE, 32'h8000_0000, 32'd0);
        drain_results();

        // count watermarks
        sc = $urandom_range(3, 10);
        rc = $urandom_range(0, sc - 1);
        lo = ((rc == 0) ? sc : rc) - 2;
        if (lo < 0) lo = 0;
        load_levels(sc, rc, 64'd0, 64'd0, 1'b0);
        run_traffic(130, sc + 4, lo, 32'd255);
        drain_results();

        // byte watermarks, then cluster-update mode, then levels at their maximum
        send_idle = 77;
        recv_idle = 26;
        ss = $urandom_range(8000, 30000);
        load_levels(32'd0, 32'd0, ss, ($urandom_range(0, 1) != 0) ? ss / 2 : 64'd0, 1'b0);
        run_traffic(100, 16, 1, 32'd4095);
        drain_results();
        load_levels(32'd5, 32'd0, 64'd0, 64'd0, 1'b1);
        run_traffic(40, 9, 2, 32'd255);
        drain_results();
        load_levels(32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                    64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        run_traffic(20, 6, 0, 32'hFFFF_FFFF);
        drain_results();

        // both watermarks with full-range sizes, no idling on either side
        send_idle = 0;
        recv_idle = 0;
        load_levels(32'd8, 32'd0, 64'h3_0000_0000, 64'h1_8000_0000, 1'b0);
        run_traffic(110, 11, 4, 32'hFFFF_FFFF);
        drain_results();

        $display("covered %0d input words and %0d result words: %0d releases, %0d stop events",
                 sb.n_words, sb.n_results, sb.n_releases, sb.n_stop_events);
        $display("%0d underflows, %0d table-full words, longest resume drain %0d, %0d mismatches",
                 sb.n_underflows, sb.n_full, longest_drain, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("[queue_watermark_flow_control] OK");
        end else begin
            $display("[queue_watermark_flow_control] ERROR");
        end
        $finish;
    end

endmodule
